// File: sv/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg: shared types and constants of the per-client token-bucket limiter
// Holds the slot entry layout, the controller states, the command and status
// structs between controller and datapath, and the fixed codes and values.
// ----------------------------------------------------------------------------
package ptbl_pkg;

  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int TOK_W   = 8;
  localparam int SLOT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Whole seconds from milliseconds: q = (x * RECIP_1000) >> RECIP_SHIFT,
  // exact for every 32-bit x. The quotient reaches 4294967, so it needs 23 bits.
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          QUOT_W      = 23;
  localparam int          ADD_W       = QUOT_W + TOK_W;

  // Operation codes
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEANUP_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT     = 2'd3;

  // Register reset values
  localparam logic [TOK_W-1:0]  RST_MAX_TOKENS       = 8'd10;
  localparam logic [TOK_W-1:0]  RST_REFILL_RATE      = 8'd1;
  localparam logic [TIME_W-1:0] RST_CLEANUP_INTERVAL = 32'd60000;
  localparam logic [TIME_W-1:0] RST_IDLE_TIMEOUT     = 32'd300000;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TOK_W-1:0]  tokens;
    logic [TIME_W-1:0] last_refill;
    logic [TIME_W-1:0] last_request;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_UPDATE,
    ST_EMIT_NC,
    ST_SWEEP_CHK,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic div;
    logic mul;
    logic update;
    logic emit_nc;
    logic sweep_chk;
    logic sweep_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_sweep;
    logic has_client;
    logic scan_done;
    logic sweep_last;
    logic sweep_due;
    logic out_free;
  } dp_stat_t;

endpackage

// File: sv/ptbl_if.sv
// ----------------------------------------------------------------------------
// ptbl_req_if / ptbl_rsp_if: request and result channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface ptbl_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        has_client;
  logic [31:0] client_addr;
  logic [31:0] now_ms;

  modport source (output valid, opcode, has_client, client_addr, now_ms, input ready);
  modport sink   (input valid, opcode, has_client, client_addr, now_ms, output ready);
endinterface

interface ptbl_rsp_if;
  logic       valid;
  logic       ready;
  logic       allowed;
  logic [4:0] slot_used;
  logic [7:0] tokens_left;

  modport source (output valid, allowed, slot_used, tokens_left, input ready);
  modport sink   (input valid, allowed, slot_used, tokens_left, output ready);
endinterface

// File: sv/ptbl_ram.sv
// ----------------------------------------------------------------------------
// ptbl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/ptbl_ctrl.sv
// ----------------------------------------------------------------------------
// ptbl_ctrl: limiter sequencer
// Steps one transaction through scan, refill and commit, sweep, or ST_EMIT_NC.
// ----------------------------------------------------------------------------
module ptbl_ctrl
  import ptbl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  dp_stat_t  stat,
  output logic      in_ready,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.op_sweep) begin
            state_next = ST_SWEEP_CHK;
          end else if (stat.has_client) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT_NC;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_UPDATE;
      ST_UPDATE, ST_EMIT_NC: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP_CHK: state_next = stat.sweep_due ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: begin
        if (stat.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN:      cmd.scan_step  = 1'b1;
      ST_DIV:       cmd.div        = 1'b1;
      ST_MUL:       cmd.mul        = 1'b1;
      ST_UPDATE:    cmd.update     = stat.out_free;
      ST_EMIT_NC:   cmd.emit_nc    = stat.out_free;
      ST_SWEEP_CHK: cmd.sweep_chk  = 1'b1;
      ST_SWEEP:     cmd.sweep_step = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: sv/ptbl_dp.sv
// ----------------------------------------------------------------------------
// ptbl_dp: limiter datapath
// Configuration registers, slot table with valid bits, scan pointers,
// victim tracking, refill arithmetic and the result register.
// ----------------------------------------------------------------------------
module ptbl_dp
  import ptbl_pkg::*;
#(
  parameter int BUCKETS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_opcode,
  input  logic                  in_has_client,
  input  logic [KEY_W-1:0]      in_client_addr,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_allowed,
  output logic [SLOT_W-1:0]     out_slot_used,
  output logic [TOK_W-1:0]      out_tokens_left,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat
);

  localparam int             IW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [IW-1:0]  LAST = IW'(BUCKETS - 1);
  localparam int             EW   = $bits(entry_t);

  // Configuration
  logic [TOK_W-1:0]  max_tokens;
  logic [TOK_W-1:0]  refill_rate;
  logic [TIME_W-1:0] cleanup_interval;
  logic [TIME_W-1:0] idle_timeout;

  // Current item
  logic [KEY_W-1:0]  addr;
  logic [TIME_W-1:0] now;

  // Table state
  logic [BUCKETS-1:0] slot_valid;
  logic [TIME_W-1:0]  last_sweep;

  // Scan
  logic [IW-1:0]     ptr;
  logic [IW-1:0]     chk_idx;
  logic              chk_valid;
  logic [IW-1:0]     victim_idx;
  logic [TIME_W-1:0] victim_time;
  logic [IW-1:0]     slot_sel;

  // Refill
  logic [TOK_W-1:0]  ent_tokens;
  logic [TIME_W-1:0] ent_refill;
  logic [QUOT_W-1:0] quot;
  logic [ADD_W-1:0]  add_tok;

  logic [EW-1:0] rdata;
  logic [EW-1:0] wdata;
  entry_t        rd;
  entry_t        wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens       <= RST_MAX_TOKENS;
      refill_rate      <= RST_REFILL_RATE;
      cleanup_interval <= RST_CLEANUP_INTERVAL;
      idle_timeout     <= RST_IDLE_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_TOKENS:       max_tokens       <= cfg_data[TOK_W-1:0];
        REG_REFILL_RATE:      refill_rate      <= cfg_data[TOK_W-1:0];
        REG_CLEANUP_INTERVAL: cleanup_interval <= cfg_data[TIME_W-1:0];
        REG_IDLE_TIMEOUT:     idle_timeout     <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan compare on the entry read out in the previous cycle
  logic              chk_slot_valid;
  logic              key_eq;
  logic              key_match;
  logic              hit;
  logic              is_last;
  logic              older;
  logic [IW-1:0]     victim_idx_n;
  logic [TIME_W-1:0] victim_time_n;
  logic              expired;
  logic              sweep_due;

  assign rd             = entry_t'(rdata);
  assign chk_slot_valid = slot_valid[chk_idx];
  assign key_eq         = (rd.key == addr);
  assign key_match      = chk_slot_valid && key_eq;
  assign hit            = !chk_slot_valid || key_eq;
  assign is_last        = (chk_idx == LAST);
  assign older          = (rd.last_request < victim_time);
  assign victim_idx_n   = older ? chk_idx : victim_idx;
  assign victim_time_n  = older ? rd.last_request : victim_time;
  assign expired        = chk_slot_valid && ((now - rd.last_request) > idle_timeout);
  assign sweep_due      = ((now - last_sweep) >= cleanup_interval);

  // Refill arithmetic
  logic [TIME_W-1:0]        elapsed;
  logic [TIME_W+28:0]       prod;
  logic [ADD_W:0]           sum;
  logic                     refilled;
  logic [TOK_W-1:0]         tok1;
  logic                     grant;
  logic [TOK_W-1:0]         tok2;
  logic [TIME_W-1:0]        refill_new;
  logic [IW+SLOT_W-1:0]     slot_ext;

  assign elapsed    = now - ent_refill;
  assign prod       = (TIME_W + 29)'(elapsed) * (TIME_W + 29)'(RECIP_1000);
  assign sum        = (ADD_W + 1)'(ent_tokens) + (ADD_W + 1)'(add_tok);
  assign refilled   = (add_tok != '0);
  assign tok1       = !refilled ? ent_tokens :
                      (sum > (ADD_W + 1)'(max_tokens)) ? max_tokens : sum[TOK_W-1:0];
  assign grant      = (tok1 != '0);
  assign tok2       = grant ? tok1 - TOK_W'(1) : tok1;
  assign refill_new = refilled ? now : ent_refill;
  assign slot_ext   = {SLOT_W'(0), slot_sel};

  assign wr.key          = addr;
  assign wr.tokens       = tok2;
  assign wr.last_refill  = refill_new;
  assign wr.last_request = now;
  assign wdata           = EW'(wr);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr        <= in_client_addr;
      now         <= in_now_ms;
      victim_idx  <= '0;
      victim_time <= in_now_ms;
      ptr         <= '0;
    end
    if (cmd.scan_step || cmd.sweep_step) begin
      ptr     <= (ptr == LAST) ? ptr : ptr + IW'(1);
      chk_idx <= ptr;
    end
    if (cmd.scan_step && chk_valid) begin
      victim_idx  <= victim_idx_n;
      victim_time <= victim_time_n;
      if (hit || is_last) begin
        slot_sel <= hit ? chk_idx : victim_idx_n;
        if (key_match) begin
          ent_tokens <= rd.tokens;
          ent_refill <= rd.last_refill;
        end else begin
          ent_tokens <= max_tokens;
          ent_refill <= now;
        end
      end
    end
    if (cmd.div) begin
      quot <= prod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd.mul) begin
      add_tok <= ADD_W'(quot) * ADD_W'(refill_rate);
    end
    if (cmd.update) begin
      out_allowed     <= grant;
      out_slot_used   <= slot_ext[SLOT_W-1:0];
      out_tokens_left <= tok2;
    end else if (cmd.emit_nc) begin
      out_allowed     <= 1'b1;
      out_slot_used   <= '0;
      out_tokens_left <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      last_sweep <= '0;
      chk_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan_step || cmd.sweep_step) begin
        chk_valid <= 1'b1;
      end
      if (cmd.sweep_chk && sweep_due) begin
        last_sweep <= now;
      end
      if (cmd.sweep_step && chk_valid && expired) begin
        slot_valid[chk_idx] <= 1'b0;
      end
      if (cmd.update) begin
        slot_valid[slot_sel] <= 1'b1;
      end
      if (cmd.update || cmd.emit_nc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  ptbl_ram #(
    .WIDTH (EW),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (slot_sel),
    .wdata (wdata),
    .re    (cmd.scan_step || cmd.sweep_step),
    .raddr (ptr),
    .rdata (rdata)
  );

  assign stat.op_sweep   = (in_opcode == OP_SWEEP);
  assign stat.has_client = in_has_client;
  assign stat.scan_done  = chk_valid && (hit || is_last);
  assign stat.sweep_last = chk_valid && is_last;
  assign stat.sweep_due  = sweep_due;
  assign stat.out_free   = !out_valid || out_ready;

  // A committed request leaves its slot occupied.
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> slot_valid[$past(slot_sel)])
    else $error("committed slot not marked valid");

  // A denied request always reports an empty bucket.
  a_deny_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_allowed) |-> (out_tokens_left == '0))
    else $error("denied request with tokens left");

  // A sweep only frees slots, it never occupies one.
  a_sweep_no_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_step |=> ($countones(slot_valid) <= $countones($past(slot_valid))))
    else $error("sweep occupied a slot");

  // The chosen slot lies inside the table.
  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (slot_sel <= LAST))
    else $error("slot index beyond table");

endmodule

// File: sv/per_client_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// per_client_token_bucket_limiter: per-client token-bucket request limiter
// Admits or rate-limits requests per client address against a table of
// token buckets, and frees idle clients on a periodic sweep transaction.
// ----------------------------------------------------------------------------
//
//  Channel   Role    Handshake          Payload
//  --------  ------  -----------------  -------------------------------------
//  req       sink    valid / ready      opcode, has_client, client_addr, now_ms
//  rsp       source  valid / ready      allowed, slot_used, tokens_left
//  cfg       sink    cfg_we (no wait)   cfg_idx, cfg_data
//
//  Steps: a request check is accepted, then scans the table in slot order
//  until a slot matches or is empty, or the whole table when it is full and
//  a slot is evicted, then passes through divide, multiply and commit.
//  The scan reads one table entry per cycle through the single RAM read port.
//  A request without address goes straight to its result. A sweep checks its
//  interval and scans every slot when due. Sweeps give no result transaction.
//  Reset clears the slot valid bits and restores the register defaults; the
//  table RAM itself needs no clearing pass. One transaction is in flight at
//  a time; a result waiting on rsp.ready holds only the commit of the next.
//
module per_client_token_bucket_limiter
  import ptbl_pkg::*;
#(
  parameter int BUCKETS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  ptbl_req_if.sink              req,
  ptbl_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // Accept a new transaction only while the sequencer is idle.
  assign req.ready = in_ready;

  ptbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Datapath: hold the item, scan the table, refill the bucket and drive the
  // result register, which frees the request side while a result waits.
  ptbl_dp #(
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .in_opcode       (req.opcode),
    .in_has_client   (req.has_client),
    .in_client_addr  (req.client_addr),
    .in_now_ms       (req.now_ms),
    .out_ready       (rsp.ready),
    .out_valid       (rsp.valid),
    .out_allowed     (rsp.allowed),
    .out_slot_used   (rsp.slot_used),
    .out_tokens_left (rsp.tokens_left),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

// File: verif/tb_per_client_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// tb_per_client_token_bucket_limiter: self-checking bench of the rate limiter
// Drives request checks and sweeps through the request channel and compares
// every result against a cycle-free admission predictor kept in the bench.
// A short directed table comes first, then randomized traffic phases. Each
// phase has its own limiter settings and one of four idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_per_client_token_bucket_limiter;
  import ptbl_pkg::*;

  localparam int BUCKETS        = 32;
  localparam int MS_PER_SEC     = 1000;
  localparam int SETTLE_CYCLES  = 48;    // long enough for a running sweep to finish
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on any channel
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 125;
  localparam int BURST_ITEMS    = 34;    // more new clients than slots, one time stamp

  typedef struct packed {
    logic              opcode;
    logic              has_client;
    logic [KEY_W-1:0]  client_addr;
    logic [TIME_W-1:0] now_ms;
  } admit_req_t;

  typedef struct packed {
    logic              allowed;
    logic [SLOT_W-1:0] slot_used;
    logic [TOK_W-1:0]  tokens_left;
  } admit_rsp_t;

  typedef enum logic {ROW_TRAFFIC, ROW_REG_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    admit_req_t            req;
    logic                  typed;  // result typed into the row, not predicted
    admit_rsp_t            want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ptbl_req_if req_if ();
  ptbl_rsp_if rsp_if ();

  per_client_token_bucket_limiter #(
    .BUCKETS (BUCKETS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Limiter settings as the predictor sees them.
  logic [TOK_W-1:0]  lim_max_tokens     = RST_MAX_TOKENS;
  logic [TOK_W-1:0]  lim_refill_rate    = RST_REFILL_RATE;
  logic [TIME_W-1:0] lim_sweep_interval = RST_CLEANUP_INTERVAL;
  logic [TIME_W-1:0] lim_idle_timeout   = RST_IDLE_TIMEOUT;

  // Client table as the predictor sees it.
  logic              slot_live     [BUCKETS];
  logic [KEY_W-1:0]  slot_owner    [BUCKETS];
  logic [TOK_W-1:0]  slot_bucket   [BUCKETS];
  logic [TIME_W-1:0] slot_refill_at[BUCKETS];
  logic [TIME_W-1:0] slot_seen_at  [BUCKETS];
  logic [TIME_W-1:0] sweep_at = '0;

  admit_rsp_t pending_verdicts[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int errors         = 0;
  int stall_cycles   = 0;
  int n_checks = 0, n_denied = 0, n_evictions = 0;
  int n_sweeps = 0, n_sweeps_run = 0, n_freed = 0, n_results = 0;

  initial begin
    for (int i = 0; i < BUCKETS; i++) begin
      slot_live[i]      = 1'b0;
      slot_owner[i]     = '0;
      slot_bucket[i]    = '0;
      slot_refill_at[i] = '0;
      slot_seen_at[i]   = '0;
    end
  end

  // Work out the verdict of one accepted transaction and advance the table.
  // Return 1 when the transaction produces a result.
  function automatic bit predict_admission(input admit_req_t r, output admit_rsp_t v);
    int                s;
    bit                hit;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] elapsed;
    longint unsigned   add;
    longint unsigned   sum;
    v = '0;
    if (r.opcode == OP_SWEEP) begin
      n_sweeps++;
      elapsed = r.now_ms - sweep_at;
      if (elapsed >= lim_sweep_interval) begin
        n_sweeps_run++;
        sweep_at = r.now_ms;
        for (int i = 0; i < BUCKETS; i++) begin
          elapsed = r.now_ms - slot_seen_at[i];
          if (slot_live[i] && elapsed > lim_idle_timeout) begin
            slot_live[i]   = 1'b0;
            slot_bucket[i] = '0;
            n_freed++;
          end
        end
      end
      return 1'b0;
    end
    n_checks++;
    // No address: admit without touching the table.
    if (!r.has_client) begin
      v.allowed = 1'b1;
      return 1'b1;
    end
    // Scan in slot order; stop at a match or a hole, else track the stalest slot.
    // Only a strictly older time displaces the candidate, so a full table
    // touched at the current time falls back to slot 0.
    s      = 0;
    hit    = 1'b0;
    oldest = r.now_ms;
    for (int i = 0; i < BUCKETS && !hit; i++) begin
      if (!slot_live[i] || slot_owner[i] == r.client_addr) begin
        s   = i;
        hit = 1'b1;
      end else if (slot_seen_at[i] < oldest) begin
        oldest = slot_seen_at[i];
        s      = i;
      end
    end
    if (!(slot_live[s] && slot_owner[s] == r.client_addr)) begin
      if (slot_live[s]) n_evictions++;
      slot_live[s]      = 1'b1;
      slot_owner[s]     = r.client_addr;
      slot_bucket[s]    = lim_max_tokens;
      slot_refill_at[s] = r.now_ms;
    end
    // Refill whole seconds only; the refill time moves only when tokens land.
    elapsed = r.now_ms - slot_refill_at[s];
    add     = 64'(elapsed / MS_PER_SEC);
    add     = add * 64'(lim_refill_rate);
    if (add > 0) begin
      sum               = 64'(slot_bucket[s]) + add;
      slot_bucket[s]    = (sum > 64'(lim_max_tokens)) ? lim_max_tokens : TOK_W'(sum);
      slot_refill_at[s] = r.now_ms;
    end
    slot_seen_at[s] = r.now_ms;
    if (slot_bucket[s] > 0) begin
      slot_bucket[s]--;
      v.allowed = 1'b1;
    end else begin
      n_denied++;
    end
    v.slot_used   = SLOT_W'(s);
    v.tokens_left = slot_bucket[s];
    return 1'b1;
  endfunction

  function automatic stim_row_t traffic_row(input logic op, input int hc,
                                            input logic [KEY_W-1:0] addr,
                                            input logic [TIME_W-1:0] now,
                                            input int typed, input int ok,
                                            input int slot,
                                            input int tok);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_TRAFFIC;
    row.req  = '{opcode: op, has_client: 1'(hc), client_addr: addr, now_ms: now};
    row.typed = 1'(typed);
    row.want = '{allowed: 1'(ok), slot_used: SLOT_W'(slot), tokens_left: TOK_W'(tok)};
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_REG_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Present one transaction; hold it until accepted. Enter and leave at a
  // falling edge so that the next item can be driven without a gap.
  task automatic send_req(input admit_req_t r, input logic typed, input admit_rsp_t want);
    admit_rsp_t verdict;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.opcode      = r.opcode;
    req_if.has_client  = r.has_client;
    req_if.client_addr = r.client_addr;
    req_if.now_ms      = r.now_ms;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    if (predict_admission(r, verdict)) pending_verdicts.push_back(typed ? want : verdict);
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result has been taken.
  task automatic hold_for_results();
    req_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // Hold until the block is idle: results drained and any sweep finished.
  task automatic settle_idle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    case (idx)
      REG_MAX_TOKENS:       lim_max_tokens     = val[TOK_W-1:0];
      REG_REFILL_RATE:      lim_refill_rate    = val[TOK_W-1:0];
      REG_CLEANUP_INTERVAL: lim_sweep_interval = val[TIME_W-1:0];
      REG_IDLE_TIMEOUT:     lim_idle_timeout   = val[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Result side: decide ready at each falling edge, stalling at the phase's rate.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transaction against the oldest pending verdict, and
  // count cycles in which nothing moves for the watchdog.
  always @(posedge clk) begin
    admit_rsp_t got;
    admit_rsp_t want;
    if (rst === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = '{allowed: rsp_if.allowed, slot_used: rsp_if.slot_used,
              tokens_left: rsp_if.tokens_left};
      n_results++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with none expected: allowed %0d slot %0d tokens %0d",
                 $time, got.allowed, got.slot_used, got.tokens_left);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (got.allowed !== want.allowed) begin
          $display("%0t: allowed mismatch: expected %0d, actual %0d",
                   $time, want.allowed, got.allowed);
          errors++;
        end
        if (got.slot_used !== want.slot_used) begin
          $display("%0t: slot_used mismatch: expected %0d, actual %0d",
                   $time, want.slot_used, got.slot_used);
          errors++;
        end
        if (got.tokens_left !== want.tokens_left) begin
          $display("%0t: tokens_left mismatch: expected %0d, actual %0d",
                   $time, want.tokens_left, got.tokens_left);
          errors++;
        end
      end
    end
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Watchdog: end the run when nothing has moved for too long.
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles, %0d results pending",
             $time, WATCHDOG_LIMIT, pending_verdicts.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t        rows[$];
    logic [KEY_W-1:0] pool[$];
    admit_req_t       item;
    logic [TIME_W-1:0] t_ms;
    logic [CFG_DATA_W-1:0] setting[4];
    int pick;

    // Drive every input to a known value before the first edge.
    rst                = 1'b1;
    req_if.valid       = 1'b0;
    req_if.opcode      = OP_CHECK;
    req_if.has_client  = 1'b0;
    req_if.client_addr = '0;
    req_if.now_ms      = '0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_MAX_TOKENS;
    cfg_data           = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Rows with a typed result follow straight from the reset
    // settings or an extreme; the rest go through the predictor.
    //                       op        hc  client_addr   now_ms        typ ok slot tok
    rows.push_back(traffic_row(OP_CHECK, 0, 32'hFFFF_FFFF, 32'd0,         1, 1, 0, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd0,         1, 1, 0, 9));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'hFFFF_FFFF, 32'd0,         1, 1, 1, 9));
    // just under a whole second: no refill
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd999,       1, 1, 0, 8));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd1000,      0, 0, 0, 0));
    rows.push_back(reg_row(REG_MAX_TOKENS, 32'd1));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'hA5A5_A5A5, 32'd5,         1, 1, 2, 0));
    // empty bucket: rate limited
    rows.push_back(traffic_row(OP_CHECK, 1, 32'hA5A5_A5A5, 32'd900,       1, 0, 2, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'hA5A5_A5A5, 32'd1005,      0, 0, 0, 0));
    // bucket above the lowered capacity gets clipped on refill
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd3000,      0, 0, 0, 0));
    rows.push_back(reg_row(REG_MAX_TOKENS, 32'd0));
    // zero capacity: a new client starts empty
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h5A5A_5A5A, 32'd3000,      1, 0, 3, 0));
    rows.push_back(reg_row(REG_MAX_TOKENS, 32'hFFFF_FFFF));
    rows.push_back(reg_row(REG_REFILL_RATE, 32'hFFFF_FFFF));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h5A5A_5A5A, 32'd4000,      0, 0, 0, 0));
    // time steps back and across the 32-bit wrap
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h5A5A_5A5A, 32'hFFFF_FC18, 0, 0, 0, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h5A5A_5A5A, 32'd24,        0, 0, 0, 0));
    // sweep before its interval has passed; address fields ignored
    rows.push_back(traffic_row(OP_SWEEP, 1, 32'hFFFF_FFFF, 32'd30000,     0, 0, 0, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd30000,     0, 0, 0, 0));
    rows.push_back(reg_row(REG_CLEANUP_INTERVAL, 32'd0));
    rows.push_back(reg_row(REG_IDLE_TIMEOUT, 32'd0));
    // idle time equal to the timeout keeps the slot; longer frees it
    rows.push_back(traffic_row(OP_SWEEP, 0, 32'h0000_0000, 32'd30000,     0, 0, 0, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'hFFFF_FFFF, 32'd30000,     1, 1, 1, 254));
    rows.push_back(traffic_row(OP_SWEEP, 0, 32'h0000_0000, 32'd30001,     0, 0, 0, 0));
    rows.push_back(traffic_row(OP_CHECK, 1, 32'h0000_0000, 32'd30001,     0, 0, 0, 0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG_WRITE) begin
        settle_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_req(rows[i].req, rows[i].typed, rows[i].want);
      end
    end

    // Random traffic phases.
    t_ms = 32'd30001;
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (p)
        0: setting = '{CFG_DATA_W'(RST_MAX_TOKENS), CFG_DATA_W'(RST_REFILL_RATE),
                       RST_CLEANUP_INTERVAL, RST_IDLE_TIMEOUT};
        1: setting = '{32'd1, 32'd0, 32'd0, 32'd0};
        2: setting = '{32'd255, 32'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        3: setting = '{32'd4, 32'd2, 32'd5000, 32'd20000};
        5: setting = '{32'd0, 32'd3, 32'd1000, 32'd8000};
        6: setting = '{32'd3, 32'd1, 32'd2000, 32'd6000};
        default: setting = '{$urandom_range(255), $urandom_range(255),
                             $urandom_range(100000), $urandom_range(400000)};
      endcase
      // Reconfigure only once the block has gone quiet.
      settle_idle();
      write_reg(REG_MAX_TOKENS,       setting[0]);
      write_reg(REG_REFILL_RATE,      setting[1]);
      write_reg(REG_CLEANUP_INTERVAL, setting[2]);
      write_reg(REG_IDLE_TIMEOUT,     setting[3]);

      // Client pool: sometimes smaller than the table, sometimes larger so
      // that lookups run to the end and evict.
      pool.delete();
      repeat ($urandom_range(8, 48)) pool.push_back($urandom);

      // Open with a burst of new clients at one time stamp: fills the table,
      // evicts stale slots, then falls back to slot 0 on the tie.
      t_ms = t_ms + $urandom_range(1500);
      for (int n = 0; n < BURST_ITEMS; n++) begin
        item = '{opcode: OP_CHECK, has_client: 1'b1, client_addr: $urandom, now_ms: t_ms};
        send_req(item, 1'b0, '0);
      end

      for (int n = BURST_ITEMS; n < PHASE_ITEMS; n++) begin
        // Pause halfway until the table has answered everything.
        if (n == PHASE_ITEMS / 2) hold_for_results();
        pick = $urandom_range(99);
        if (pick < 25)      t_ms = t_ms;
        else if (pick < 75) t_ms = t_ms + $urandom_range(1500);
        else if (pick < 90) t_ms = t_ms + $urandom_range(1000, 60000);
        else if (pick < 97) t_ms = t_ms + $urandom_range(100000, 400000);
        else                t_ms = $urandom;
        item = '{opcode: OP_CHECK, has_client: 1'b1, client_addr: '0, now_ms: t_ms};
        pick = $urandom_range(99);
        if (pick < 78) begin
          item.client_addr = pool[$urandom_range(pool.size() - 1)];
        end else if (pick < 84) begin
          item.has_client  = 1'b0;
          item.client_addr = $urandom;
        end else if (pick < 94) begin
          item.opcode      = OP_SWEEP;
          item.has_client  = 1'($urandom_range(1));
          item.client_addr = $urandom;
        end else begin
          item.client_addr = $urandom;
        end
        send_req(item, 1'b0, '0);
      end
    end

    // Drain and let any trailing sweep finish.
    settle_idle();

    $display("Ran %0d request checks (%0d denied, %0d evictions) and %0d sweeps (%0d ran, %0d freed)",
             n_checks, n_denied, n_evictions, n_sweeps, n_sweeps_run, n_freed);
    $display("Checked %0d results over a directed table and %0d randomized phases",
             n_results, PHASES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ptbl_pkg.sv
sv/ptbl_if.sv
sv/ptbl_ram.sv
sv/ptbl_ctrl.sv
sv/ptbl_dp.sv
sv/per_client_token_bucket_limiter.sv
verif/tb_per_client_token_bucket_limiter.sv
